// ===== hdl/vqdm_pkg.sv =====
// Package for the virtqueue descriptor manager: field widths, result codes,
// controller state type and the command and status structs between modules.
// No dependencies.
`default_nettype none

package vqdm_pkg;

    localparam int ADDR_W  = 64;
    localparam int LEN_W   = 16;
    localparam int IDX_W   = 8;
    localparam int SLOT_W  = 8;
    localparam int CNT_W   = 9;
    localparam int STS_W   = 2;
    localparam int CFG_W   = 4;
    localparam int AVAIL_W = 16;
    localparam int DESC_W  = 1 + LEN_W + ADDR_W;

    // Largest queue size, as log2, that the register can select.
    localparam int LG_LIMIT = 8;

    localparam logic [AVAIL_W-1:0] AVAIL_MASK = 16'hFFFF;

    localparam logic [STS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [STS_W-1:0] STATUS_RANGE   = 2'd2;

    localparam logic KIND_POST     = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic accept;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/vqdm_if.sv =====
// Request and result channel interfaces of the virtqueue descriptor manager.
// Depends on vqdm_pkg for the field widths.
`default_nettype none

interface vqdm_req_if
    import vqdm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [ADDR_W-1:0] buffer_address;
    logic [LEN_W-1:0]  buffer_length;
    logic              device_writes;
    logic [IDX_W-1:0]  done_index;

    modport source (
        output valid, kind, buffer_address, buffer_length, device_writes, done_index,
        input  ready
    );
    modport sink (
        input  valid, kind, buffer_address, buffer_length, device_writes, done_index,
        output ready
    );
endinterface

interface vqdm_res_if
    import vqdm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STS_W-1:0]  status;
    logic [IDX_W-1:0]  descriptor_index;
    logic [SLOT_W-1:0] ring_slot;
    logic              notify;
    logic [ADDR_W-1:0] stored_address;
    logic [LEN_W-1:0]  stored_length;
    logic [CNT_W-1:0]  free_left;

    modport source (
        output valid, status, descriptor_index, ring_slot, notify,
               stored_address, stored_length, free_left,
        input  ready
    );
    modport sink (
        input  valid, status, descriptor_index, ring_slot, notify,
               stored_address, stored_length, free_left,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/vqdm_ctrl.sv =====
// Controller state machine of the virtqueue descriptor manager.
// Depends on vqdm_pkg for the state type and the command and status structs.
`default_nettype none

module vqdm_ctrl
    import vqdm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    input  wire t_sts i_sts,
    output logic      o_req_ready,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_req_ready  = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The update waits until the result register can take the result.
                if (!i_sts.out_full) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/vqdm_datapath.sv =====
// Datapath of the virtqueue descriptor manager: descriptor and link memories,
// free list registers, available index and the result register.
// Depends on vqdm_pkg and on vqdm_res_if.
`default_nettype none

module vqdm_datapath
    import vqdm_pkg::*;
#(
    parameter int MAX_DESCRIPTORS = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic              i_kind,
    input  wire logic [ADDR_W-1:0] i_buffer_address,
    input  wire logic [LEN_W-1:0]  i_buffer_length,
    input  wire logic              i_device_writes,
    input  wire logic [IDX_W-1:0]  i_done_index,
    vqdm_res_if.source             o_res
);

    // Queue sizes are powers of two no larger than MAX_DESCRIPTORS or 256.
    localparam int LG_MAXD = $clog2(MAX_DESCRIPTORS + 1) - 1;
    localparam int LG_CAP  = (LG_MAXD < LG_LIMIT) ? LG_MAXD : LG_LIMIT;
    localparam int DEPTH   = 1 << LG_CAP;
    localparam int IW      = (LG_CAP > 0) ? LG_CAP : 1;

    logic [CNT_W-1:0]  link_mem [DEPTH];
    logic [DESC_W-1:0] desc_mem [DEPTH];
    logic [DEPTH-1:0]  r_link_vld;

    logic [CFG_W-1:0]   r_qlg;
    logic [CNT_W-1:0]   r_free_head;
    logic [CNT_W-1:0]   r_free_cnt;
    logic [AVAIL_W-1:0] r_avail;

    logic              r_kind;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic              r_wr;
    logic [IDX_W-1:0]  r_done;

    logic [CNT_W-1:0]  r_link_rd;
    logic              r_link_rd_vld;
    logic [DESC_W-1:0] r_desc_rd;

    logic              r_out_valid;
    logic [STS_W-1:0]  r_status;
    logic [IDX_W-1:0]  r_desc_idx;
    logic [SLOT_W-1:0] r_slot;
    logic              r_notify;
    logic [ADDR_W-1:0] r_saddr;
    logic [LEN_W-1:0]  r_slen;
    logic [CNT_W-1:0]  r_free_left;

    logic [CFG_W-1:0]  cfg_lg;
    logic [CNT_W-1:0]  cfg_q;
    logic [CNT_W-1:0]  qsize;
    logic [SLOT_W-1:0] slot_mask;
    logic [IW-1:0]     head_idx;
    logic [IW-1:0]     done_idx;
    logic [IW-1:0]     cap_done_idx;
    logic [CNT_W-1:0]  link_next;
    logic              post_ok;
    logic              cmp_ok;
    logic              desc_we;
    logic              link_we;
    logic [CNT_W-1:0]  cnt_inc;

    assign cfg_lg = (i_cfg_data > CFG_W'(LG_CAP)) ? CFG_W'(LG_CAP) : i_cfg_data;
    assign cfg_q  = CNT_W'(1) << cfg_lg;

    assign qsize        = CNT_W'(1) << r_qlg;
    assign slot_mask    = SLOT_W'(qsize - CNT_W'(1));
    assign head_idx     = r_free_head[IW-1:0];
    assign cap_done_idx = i_done_index[IW-1:0];
    assign done_idx     = r_done[IW-1:0];

    // A link that was never written since the last re-initialisation still
    // holds its initial value, the index plus one.
    assign link_next = r_link_rd_vld ? r_link_rd : (r_free_head + CNT_W'(1));
    assign post_ok   = (r_free_cnt != '0) && (r_free_head < qsize);
    assign cmp_ok    = {1'b0, r_done} < qsize;
    assign cnt_inc   = (r_free_cnt < qsize) ? (r_free_cnt + CNT_W'(1)) : r_free_cnt;

    assign desc_we = i_cmd.commit && (r_kind == KIND_POST) && post_ok;
    assign link_we = i_cmd.commit && (r_kind == KIND_COMPLETE) && cmp_ok;

    assign o_sts.out_full = r_out_valid && !o_res.ready;

    // Memory reads are issued when the request is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_link_rd     <= link_mem[head_idx];
            r_link_rd_vld <= r_link_vld[head_idx];
            r_desc_rd     <= desc_mem[cap_done_idx];
            r_kind        <= i_kind;
            r_addr        <= i_buffer_address;
            r_len         <= i_buffer_length;
            r_wr          <= i_device_writes;
            r_done        <= i_done_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (desc_we) begin
            desc_mem[head_idx] <= {r_wr, r_len, r_addr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[done_idx] <= r_free_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlg       <= CFG_W'(LG_CAP);
            r_free_head <= '0;
            r_free_cnt  <= CNT_W'(DEPTH);
            r_avail     <= '0;
            r_link_vld  <= '0;
        end else if (i_cfg_we) begin
            r_qlg       <= cfg_lg;
            r_free_head <= '0;
            r_free_cnt  <= cfg_q;
            r_avail     <= '0;
            r_link_vld  <= '0;
        end else if (desc_we) begin
            r_free_head <= link_next;
            r_free_cnt  <= r_free_cnt - CNT_W'(1);
            r_avail     <= (r_avail + AVAIL_W'(1)) & AVAIL_MASK;
        end else if (link_we) begin
            r_free_head          <= {1'b0, r_done};
            r_free_cnt           <= cnt_inc;
            r_link_vld[done_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_slot      <= '0;
            r_notify    <= 1'b0;
            r_saddr     <= '0;
            r_slen      <= '0;
            r_desc_idx  <= '0;
            r_free_left <= r_free_cnt;
            if (r_kind == KIND_POST) begin
                if (post_ok) begin
                    r_status    <= STATUS_OK;
                    r_desc_idx  <= r_free_head[IDX_W-1:0];
                    r_slot      <= r_avail[SLOT_W-1:0] & slot_mask;
                    r_notify    <= 1'b1;
                    r_free_left <= r_free_cnt - CNT_W'(1);
                end else begin
                    r_status <= STATUS_NO_FREE;
                end
            end else begin
                r_desc_idx <= r_done;
                if (cmp_ok) begin
                    r_status    <= STATUS_OK;
                    r_saddr     <= r_desc_rd[ADDR_W-1:0];
                    r_slen      <= r_desc_rd[ADDR_W +: LEN_W];
                    r_free_left <= cnt_inc;
                end else begin
                    r_status <= STATUS_RANGE;
                end
            end
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.status           = r_status;
    assign o_res.descriptor_index = r_desc_idx;
    assign o_res.ring_slot        = r_slot;
    assign o_res.notify           = r_notify;
    assign o_res.stored_address   = r_saddr;
    assign o_res.stored_length    = r_slen;
    assign o_res.free_left        = r_free_left;

endmodule

`default_nettype wire

// ===== hdl/virtqueue_descriptor_manager.sv =====
// Top level of the split-virtqueue descriptor manager, driver side.
// Depends on vqdm_pkg, vqdm_if, vqdm_ctrl and vqdm_datapath.
`default_nettype none

// The block keeps the descriptor table of a split virtqueue and a free list
// threaded through the next links. A post request takes the descriptor at the
// head of the free list, stores the buffer in it and returns the descriptor
// index, the available-ring slot (the 16-bit available index masked to the
// queue size) and a notify flag; a post with no free descriptor returns the
// no-free status. A complete request pushes a descriptor back on the head of
// the free list and returns the address and length stored for it; an index
// at or beyond the queue size returns the out-of-range status. Accepting a
// request issues the registered reads of the link and descriptor memories;
// the execute state then commits the update and loads the result register,
// and no new request is accepted until that commit. The result register lets
// the next request be accepted while a result still waits; a further request
// then holds in its execute state until the result is taken. The queue size
// register (log2, values above eight count as eight, limited by
// MAX_DESCRIPTORS) may only be written while the block is idle; every
// write, like reset, rebuilds the free list at once through per-entry valid
// bits on the link memory, so no clearing pass is needed. Descriptor
// contents are not cleared; completing a descriptor that was never posted
// returns undefined address and length.

module virtqueue_descriptor_manager
    import vqdm_pkg::*;
#(
    parameter int MAX_DESCRIPTORS = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    vqdm_req_if.sink              i_req,
    vqdm_res_if.source            o_res
);

    t_cmd cmd;
    t_sts sts;
    logic req_ready;

    assign i_req.ready = req_ready;

    // The controller sequences each request; the datapath holds the memories, the free list and the result register.
    vqdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (sts),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    vqdm_datapath #(
        .MAX_DESCRIPTORS (MAX_DESCRIPTORS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_kind           (i_req.kind),
        .i_buffer_address (i_req.buffer_address),
        .i_buffer_length  (i_req.buffer_length),
        .i_device_writes  (i_req.device_writes),
        .i_done_index     (i_req.done_index),
        .o_res            (o_res)
    );

endmodule

`default_nettype wire
